### hw/rtl/ersc_pkg.sv
// Shared types and constants for the encoder RPM speed controller.
package ersc_pkg;

	localparam int RPM_W    = 26;
	localparam int GAIN_W   = 8;
	localparam int THR_W    = 16;
	localparam int PBITS_W  = 5;
	localparam int CMD_W    = 2;
	localparam int PERIOD_W = 32;
	localparam int TGT_W    = 16;
	localparam int FRAC_W   = 17;
	localparam int DUTY_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 26;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READY_THR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_BITS  = 2'd3;

	localparam logic [RPM_W-1:0]   RST_RPM_NUM   = 26'd60000000;
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN = 8'd1;
	localparam logic [THR_W-1:0]   RST_READY_THR = 16'd3277;
	localparam logic [PBITS_W-1:0] RST_PWM_BITS  = 5'd8;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [PERIOD_W-1:0] encoder_period;
		logic [TGT_W-1:0]    set_rpm;
		logic [FRAC_W-1:0]   start_duty;
	} in_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [RPM_W-1:0]  measured_rpm;
		logic              ready_res;
	} out_t;

	typedef struct packed {
		logic [RPM_W-1:0]   rpm_numerator;
		logic [GAIN_W-1:0]  prop_gain;
		logic [THR_W-1:0]   ready_threshold;
		logic [PBITS_W-1:0] pwm_bits;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic mul_en;
		logic sum_en;
		logic commit;
	} ctrl_t;

	typedef struct packed {
		logic in_is_tick;
		logic div_done;
	} stat_t;

endpackage

### hw/rtl/ersc_div.sv
// Restoring divider, one quotient bit per cycle.
module ersc_div
	import ersc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [RPM_W-1:0]    num,
	input  logic [PERIOD_W-1:0] den,
	output logic [RPM_W-1:0]    quo,
	output logic                done
);

	localparam int CNT_W = $clog2(RPM_W + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [PERIOD_W:0]   rem_q;
	logic [RPM_W-1:0]    quo_q;
	logic [PERIOD_W-1:0] den_q;
	logic [PERIOD_W:0]   shifted;
	logic                fits;

	assign shifted = {rem_q[PERIOD_W-1:0], quo_q[RPM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(RPM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[RPM_W-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

### hw/rtl/ersc_dp.sv
// Datapath: speed, duty update, ready check and result register.
module ersc_dp
	import ersc_pkg::*;
#(
	parameter int MAX_PWM_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  in_t   in_data,
	input  ctrl_t ctrl,
	output stat_t stat,
	output out_t  out_data
);

	localparam int DW     = MAX_PWM_BITS;
	localparam int EW     = $clog2(MAX_PWM_BITS + 1);
	localparam int ERR_W  = RPM_W + 1;
	localparam int PROD_W = ERR_W + GAIN_W + 1;
	localparam int SUM_W  = ((DW + 1) > PROD_W ? (DW + 1) : PROD_W) + 1;
	localparam int SD_W   = FRAC_W + DW;
	localparam int CMP_W  = RPM_W + 16;

	logic [CMD_W-1:0]   cmd_q;
	logic [TGT_W-1:0]   tgt_in_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               pzero_q;

	logic [DW-1:0]      duty_q;
	logic [TGT_W-1:0]   target_q;
	logic [RPM_W-1:0]   speed_q;
	logic               ready_q;

	logic [RPM_W-1:0]   div_quo;
	logic               div_done;

	logic [RPM_W-1:0]   spd_new_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [RPM_W-1:0]   mag_q;
	logic [2*TGT_W-1:0] thr_prod_q;
	logic [DW-1:0]      sum_duty_q;
	logic               hit_q;

	out_t               out_q;

	logic [EW-1:0]      eff;
	logic [DW-1:0]      mx;
	logic [RPM_W-1:0]   spd;
	logic signed [ERR_W-1:0] err;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0] sum;
	logic [SD_W-1:0]    sd_wide;
	logic [DW:0]        sd_shr;
	logic [DW-1:0]      sd_duty;
	logic [DW-1:0]      duty_nx;
	logic [TGT_W-1:0]   target_nx;
	logic [RPM_W-1:0]   speed_nx;
	logic               ready_nx;

	ersc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (cfg.rpm_numerator),
		.den    (in_data.encoder_period),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign stat.in_is_tick = (in_data.cmd == CMD_TICK);
	assign stat.div_done   = div_done;

	always_comb begin
		if (cfg.pwm_bits == '0) begin
			eff = EW'(1);
		end else if ({1'b0, cfg.pwm_bits} > (PBITS_W + 1)'(MAX_PWM_BITS)) begin
			eff = EW'(MAX_PWM_BITS);
		end else begin
			eff = EW'(cfg.pwm_bits);
		end
	end

	assign mx = ~({DW{1'b1}} << eff);

	assign spd  = pzero_q ? '0 : div_quo;
	assign err  = $signed(ERR_W'(target_q)) - $signed(ERR_W'(spd));
	assign prod = $signed({1'b0, cfg.prop_gain}) * err;

	assign sum = $signed(SUM_W'(duty_q)) + SUM_W'(prod_q);

	assign sd_wide = SD_W'(frac_q) << eff;
	assign sd_shr  = sd_wide[SD_W-1:16];
	assign sd_duty = (sd_shr > {1'b0, mx}) ? mx : sd_shr[DW-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q    <= in_data.cmd;
			tgt_in_q <= in_data.set_rpm;
			frac_q   <= in_data.start_duty;
			pzero_q  <= (in_data.encoder_period == '0);
		end
		if (ctrl.mul_en) begin
			spd_new_q  <= spd;
			prod_q     <= prod;
			mag_q      <= err[ERR_W-1] ? RPM_W'(-err) : RPM_W'(err);
			thr_prod_q <= cfg.ready_threshold * target_q;
		end
		if (ctrl.sum_en) begin
			if (sum[SUM_W-1]) begin
				sum_duty_q <= '0;
			end else if (sum > $signed(SUM_W'(mx))) begin
				sum_duty_q <= mx;
			end else begin
				sum_duty_q <= sum[DW-1:0];
			end
			hit_q <= ({mag_q, 16'b0} <= CMP_W'(thr_prod_q));
		end
		if (ctrl.commit) begin
			out_q.duty         <= DUTY_W'(duty_nx);
			out_q.measured_rpm <= speed_nx;
			out_q.ready_res    <= ready_nx;
		end
	end

	always_comb begin
		duty_nx   = duty_q;
		target_nx = target_q;
		speed_nx  = speed_q;
		ready_nx  = ready_q;
		case (cmd_q)
			CMD_TICK: begin
				duty_nx  = sum_duty_q;
				speed_nx = spd_new_q;
				ready_nx = ready_q | hit_q;
			end
			CMD_START: begin
				duty_nx   = sd_duty;
				target_nx = tgt_in_q;
			end
			CMD_STOP: begin
				duty_nx   = '0;
				target_nx = '0;
			end
			default: begin
				duty_nx = duty_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q   <= '0;
			target_q <= '0;
			speed_q  <= '0;
			ready_q  <= 1'b0;
		end else if (ctrl.commit) begin
			duty_q   <= duty_nx;
			target_q <= target_nx;
			speed_q  <= speed_nx;
			ready_q  <= ready_nx;
		end
	end

	assign out_data = out_q;

endmodule

### hw/rtl/ersc_ctrl.sv
// Controller FSM sequencing divide, multiply and sum for ticks, and the result beat.
module ersc_ctrl
	import ersc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output ctrl_t ctrl
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx       = state_q;
		ctrl           = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					if (stat.in_is_tick) begin
						ctrl.div_start = 1'b1;
						state_nx       = S_DIV;
					end else begin
						state_nx = S_DONE;
					end
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				ctrl.mul_en = 1'b1;
				state_nx    = S_SUM;
			end
			S_SUM: begin
				ctrl.sum_en = 1'b1;
				state_nx    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctrl.commit = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/encoder_rpm_p_speed_control_unit.sv
// A tick beat runs the divide, multiply and sum states before its result is committed;
// start and stop go straight to commit. The 26-step restoring divider sets the tick
// time. Items are taken only after the last commits; its result beat may still wait.
// Reset clears duty, target, speed and ready, and loads the register defaults.
// Top level: configuration registers, controller and datapath.
module encoder_rpm_p_speed_control_unit
	import ersc_pkg::*;
#(
	parameter int MAX_PWM_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t  cfg_q;
	ctrl_t ctrl;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_numerator   <= RST_RPM_NUM;
			cfg_q.prop_gain       <= RST_PROP_GAIN;
			cfg_q.ready_threshold <= RST_READY_THR;
			cfg_q.pwm_bits        <= RST_PWM_BITS;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RPM_NUM:   cfg_q.rpm_numerator   <= cfg_wdata[RPM_W-1:0];
				CFG_PROP_GAIN: cfg_q.prop_gain       <= cfg_wdata[GAIN_W-1:0];
				CFG_READY_THR: cfg_q.ready_threshold <= cfg_wdata[THR_W-1:0];
				CFG_PWM_BITS:  cfg_q.pwm_bits        <= cfg_wdata[PBITS_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	ersc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	ersc_dp #(
		.MAX_PWM_BITS (MAX_PWM_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

### bench/ersc_checker.sv
// Checker for the encoder RPM speed controller: tracks register writes, predicts and compares.
module ersc_checker
	import ersc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_t                   in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PWM_BITS_CAP = 16;

	logic [RPM_W-1:0]   rpm_num_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [THR_W-1:0]   thr_q;
	logic [PBITS_W-1:0] pwm_bits_q;

	logic [DUTY_W-1:0] duty_q;
	logic [TGT_W-1:0]  target_q;
	logic [RPM_W-1:0]  speed_q;
	logic              ready_q;

	out_t status_due[$];
	out_t want;

	function automatic out_t step_controller(input in_t b);
		int unsigned       res;
		longint unsigned   duty_cap, frac, d;
		longint            tgt, spd, cur, gain, err, sum, mag;
		out_t              r;
		res = (pwm_bits_q == '0) ? 1 :
			((pwm_bits_q > PWM_BITS_CAP) ? PWM_BITS_CAP : pwm_bits_q);
		duty_cap = (64'd1 << res) - 1;
		case (b.cmd)
			CMD_TICK: begin
				speed_q = (b.encoder_period == '0) ? '0 :
					RPM_W'(64'(rpm_num_q) / 64'(b.encoder_period));
				tgt = target_q;
				spd = speed_q;
				cur = duty_q;
				gain = gain_q;
				err = tgt - spd;
				sum = cur + gain * err;
				if (sum < 0)
					sum = 0;
				if (sum > longint'(duty_cap))
					sum = longint'(duty_cap);
				duty_q = sum[DUTY_W-1:0];
				mag = (err < 0) ? -err : err;
				if (!ready_q && mag * 65536 <= longint'(thr_q) * tgt)
					ready_q = 1'b1;
			end
			CMD_START: begin
				frac = b.start_duty;
				d = (frac << res) >> 16;
				if (d > duty_cap)
					d = duty_cap;
				duty_q = d[DUTY_W-1:0];
				target_q = b.set_rpm;
			end
			CMD_STOP: begin
				duty_q = '0;
				target_q = '0;
			end
			default: ;
		endcase
		r.duty = duty_q;
		r.measured_rpm = speed_q;
		r.ready_res = ready_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_num_q = RST_RPM_NUM;
			gain_q = RST_PROP_GAIN;
			thr_q = RST_READY_THR;
			pwm_bits_q = RST_PWM_BITS;
			duty_q = '0;
			target_q = '0;
			speed_q = '0;
			ready_q = 1'b0;
			status_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RPM_NUM:   rpm_num_q = cfg_wdata[RPM_W-1:0];
					CFG_PROP_GAIN: gain_q = cfg_wdata[GAIN_W-1:0];
					CFG_READY_THR: thr_q = cfg_wdata[THR_W-1:0];
					CFG_PWM_BITS:  pwm_bits_q = cfg_wdata[PBITS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				status_due.push_back(step_controller(in_data));
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$display("%0t: result beat with nothing expected: %p", $time, out_data);
					fail_count++;
				end else begin
					want = status_due.pop_front();
					if (out_data.duty !== want.duty) begin
						$display("%0t: duty expected %0d got %0d",
							$time, want.duty, out_data.duty);
						fail_count++;
					end
					if (out_data.measured_rpm !== want.measured_rpm) begin
						$display("%0t: measured_rpm expected %0d got %0d",
							$time, want.measured_rpm, out_data.measured_rpm);
						fail_count++;
					end
					if (out_data.ready_res !== want.ready_res) begin
						$display("%0t: ready_res expected %0b got %0b",
							$time, want.ready_res, out_data.ready_res);
						fail_count++;
					end
				end
			end
			pending = status_due.size();
		end
	end

endmodule

### bench/testbench.sv
// Top of the speed controller bench: clock, reset, stimulus, register writes and verdict.
module testbench
	import ersc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_BEATS = 125;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fails;
	int                    pending;

	bit              no_idle;
	bit              hold_rx;
	logic [RPM_W-1:0] num_now;
	logic [TGT_W-1:0] tgt_now;

	encoder_rpm_p_speed_control_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	ersc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic in_t make_beat(input logic [CMD_W-1:0] cmd,
		input logic [PERIOD_W-1:0] period, input logic [TGT_W-1:0] tgt,
		input logic [FRAC_W-1:0] frac);
		in_t b;
		b.cmd = cmd;
		b.encoder_period = period;
		b.set_rpm = tgt;
		b.start_duty = frac;
		return b;
	endfunction

	// mostly ticks with periods near the target speed, some starts, stops and noise
	function automatic in_t random_command();
		in_t             b;
		int unsigned     pick;
		longint unsigned base;
		b.encoder_period = $urandom();
		b.set_rpm = TGT_W'($urandom_range(0, 65535));
		b.start_duty = FRAC_W'($urandom_range(0, 131071));
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			b.cmd = CMD_START;
			tgt_now = b.set_rpm;
		end else if (pick < 15) begin
			b.cmd = CMD_STOP;
			tgt_now = '0;
		end else if (pick < 18) begin
			b.cmd = CMD_UNDEF;
		end else begin
			b.cmd = CMD_TICK;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				b.encoder_period = '0;
			end else if (pick > 1) begin
				base = num_now / ((tgt_now == '0) ? 1 : tgt_now);
				b.encoder_period = PERIOD_W'(base - base / 32 + $urandom_range(0, base / 16 + 2));
			end
		end
		return b;
	endfunction

	task automatic send_beat(input in_t b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [RPM_W-1:0] num, input logic [GAIN_W-1:0] gain,
		input logic [THR_W-1:0] thr, input logic [PBITS_W-1:0] bits);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_RPM_NUM;
		cfg_wdata <= CFG_DATA_W'(num);
		@(posedge clk);
		cfg_idx <= CFG_PROP_GAIN;
		cfg_wdata <= CFG_DATA_W'(gain);
		@(posedge clk);
		cfg_idx <= CFG_READY_THR;
		cfg_wdata <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_idx <= CFG_PWM_BITS;
		cfg_wdata <= CFG_DATA_W'(bits);
		@(posedge clk);
		cfg_we <= 1'b0;
		num_now = num;
	endtask

	// receiver: random stall per beat, plus one long hold-off on request
	initial begin
		int n;
		forever begin
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_rx = 1'b0;
			end
			n = no_idle ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int unsigned p;
		int unsigned i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_RPM_NUM;
		cfg_wdata = '0;
		no_idle = 1'b0;
		hold_rx = 1'b0;
		num_now = RST_RPM_NUM;
		tgt_now = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero target with a small error must not set ready
		send_beat(make_beat(CMD_TICK, 32'd60000000, 16'd0, 17'd0));
		send_beat(make_beat(CMD_TICK, 32'd3000000, 16'd0, 17'd0));
		send_beat(make_beat(CMD_START, 32'd0, 16'd1000, 17'd32768));
		send_beat(make_beat(CMD_TICK, 32'd0, 16'hFFFF, 17'h1FFFF));
		send_beat(make_beat(CMD_TICK, 32'd1, 16'd0, 17'd0));
		send_beat(make_beat(CMD_TICK, 32'hFFFF_FFFF, 16'd0, 17'd0));
		send_beat(make_beat(CMD_UNDEF, 32'hFFFF_FFFF, 16'hFFFF, 17'h1FFFF));
		send_beat(make_beat(CMD_STOP, 32'hFFFF_FFFF, 16'hFFFF, 17'h1FFFF));
		send_beat(make_beat(CMD_START, 32'd0, 16'hFFFF, 17'd65536));
		send_beat(make_beat(CMD_START, 32'd0, 16'd0, 17'h1FFFF));
		send_beat(make_beat(CMD_START, 32'd0, 16'd1000, 17'd0));
		// just outside, then just inside, the ready band
		send_beat(make_beat(CMD_TICK, 32'd57088, 16'd0, 17'd0));
		send_beat(make_beat(CMD_TICK, 32'd57142, 16'd0, 17'd0));
		send_beat(make_beat(CMD_TICK, 32'd30000, 16'd0, 17'd0));
		send_beat(make_beat(CMD_STOP, 32'd0, 16'd0, 17'd0));
		send_beat(make_beat(CMD_TICK, 32'd0, 16'd0, 17'd0));
		send_beat(make_beat(CMD_START, 32'd0, 16'd20000, 17'd65535));
		send_beat(make_beat(CMD_TICK, 32'd6000, 16'd0, 17'd0));

		for (p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: write_regs(26'd60000000, 8'd3, 16'd3277, 5'd12);
				1: write_regs(26'd1, 8'd0, 16'd0, 5'd1);
				2: write_regs(26'h3FF_FFFF, 8'd255, 16'hFFFF, 5'd16);
				3: write_regs(26'd0, 8'd7, 16'd1000, 5'd0);
				4: write_regs(26'd60000000, 8'd255, 16'hFFFF, 5'd31);
				default: write_regs(RPM_W'($urandom_range(1, 67108863)),
					GAIN_W'($urandom_range(0, 255)), THR_W'($urandom_range(0, 65535)),
					PBITS_W'($urandom_range(1, 16)));
			endcase
			for (i = 0; i < PHASE_BEATS; i++) begin
				no_idle = (i >= 40 && i < 70);
				if (p == 2 && i == 20)
					hold_rx = 1'b1;
				if (p == 4 && i == 60)
					settle();
				send_beat(random_command());
			end
			no_idle = 1'b0;
		end

		settle();
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
